@@ hdl/trs_pkg.sv @@
// ----------------------------------------------------------------------------
// trs_pkg: shared constants and types for the TRS model matrix pipeline
// Polynomial sine constants, stage numbering and the side-band payload type.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // pipeline stage numbering
  localparam int NUM_STAGES = 9;
  localparam int STG_Z      = 0;  // quadrant fold
  localparam int STG_SQ     = 1;  // z^2
  localparam int STG_INNER  = 2;  // B - C*z^2
  localparam int STG_T1     = 3;  // A - z^2*inner
  localparam int STG_SIN    = 4;  // z*t1, round, sign
  localparam int STG_PROD1  = 5;  // first angle products
  localparam int STG_PROD2  = 6;  // second angle products
  localparam int STG_SUM    = 7;  // matrix entries
  localparam int STG_OUT    = 8;  // column scale, saturate

  // Q30 sine polynomial constants
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] POLY_A  = 31'd1686629713;
  localparam logic [30:0] POLY_B  = 31'd688904866;
  localparam logic [30:0] POLY_C  = 31'd76016977;

  // position and scales ride alongside the math
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } trs_side_t;

endpackage

`default_nettype wire

@@ hdl/trs_sincos.sv @@
// ----------------------------------------------------------------------------
// trs_sincos: pipelined sine and cosine of one binary angle
// Quadrant fold, then odd polynomial in Q30, one multiply per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_sincos import trs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic [NUM_STAGES-1:0]   en,
  input  wire logic [15:0]             angle,
  output logic signed [FRAC_BITS+1:0]  sin_o,
  output logic signed [FRAC_BITS+1:0]  cos_o
);

  localparam int AW  = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam int TW  = FRAC_BITS + 2;
  localparam int RSH = 30 - FRAC_BITS;
  localparam logic [31:0] HALF = (32'd1 << RSH) >> 1;

  logic [AW-1:0] ang_w;
  logic [29:0]   frac;
  logic [1:0]    quad [2];
  logic [30:0]   z_nxt [2];

  logic [30:0] z1_r [2];
  logic        n1_r [2];
  logic [30:0] zz2_r [2], z2_r [2];
  logic        n2_r [2];
  logic [30:0] inner3_r [2], zz3_r [2], z3_r [2];
  logic        n3_r [2];
  logic [30:0] t14_r [2], z4_r [2];
  logic        n4_r [2];
  logic signed [TW-1:0] sc5_r [2];

  logic [61:0] sq [2], pc [2], pi [2], ps [2];
  logic [31:0] rnd [2];
  logic [TW-1:0] mag [2];

  assign ang_w   = AW'(angle);
  assign frac    = {ang_w[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
  assign quad[0] = ang_w[ANGLE_BITS-1:ANGLE_BITS-2];
  assign quad[1] = quad[0] + 2'd1;  // cos = sin of angle plus a quarter turn

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      z_nxt[l] = quad[l][0] ? (Q30_ONE - {1'b0, frac}) : {1'b0, frac};
      sq[l]    = 62'(z1_r[l]) * 62'(z1_r[l]);
      pc[l]    = 62'(POLY_C) * 62'(zz2_r[l]);
      pi[l]    = 62'(zz3_r[l]) * 62'(inner3_r[l]);
      ps[l]    = 62'(z4_r[l]) * 62'(t14_r[l]);
      rnd[l]   = (ps[l][61:30] + HALF) >> RSH;
      mag[l]   = rnd[l][TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en[STG_Z]) begin
        z1_r[l] <= z_nxt[l];
        n1_r[l] <= quad[l][1];
      end
      if (en[STG_SQ]) begin
        zz2_r[l] <= sq[l][60:30];
        z2_r[l]  <= z1_r[l];
        n2_r[l]  <= n1_r[l];
      end
      if (en[STG_INNER]) begin
        inner3_r[l] <= POLY_B - pc[l][60:30];
        zz3_r[l]    <= zz2_r[l];
        z3_r[l]     <= z2_r[l];
        n3_r[l]     <= n2_r[l];
      end
      if (en[STG_T1]) begin
        t14_r[l] <= POLY_A - pi[l][60:30];
        z4_r[l]  <= z3_r[l];
        n4_r[l]  <= n3_r[l];
      end
      if (en[STG_SIN]) begin
        sc5_r[l] <= n4_r[l] ? -$signed(mag[l]) : $signed(mag[l]);
      end
    end
  end

  assign sin_o = sc5_r[0];
  assign cos_o = sc5_r[1];

endmodule

`default_nettype wire

@@ hdl/trs_rotmul.sv @@
// ----------------------------------------------------------------------------
// trs_rotmul: rotation matrix Rx*Ry*Rz from sines and cosines
// Two product stages and one sum stage, all products rounded to Q.FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_rotmul import trs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic [NUM_STAGES-1:0]   en,
  input  wire logic signed [FRAC_BITS+1:0] sx,
  input  wire logic signed [FRAC_BITS+1:0] cx,
  input  wire logic signed [FRAC_BITS+1:0] sy,
  input  wire logic signed [FRAC_BITS+1:0] cy,
  input  wire logic signed [FRAC_BITS+1:0] sz,
  input  wire logic signed [FRAC_BITS+1:0] cz,
  output logic signed [FRAC_BITS+2:0]      ent_o [9]
);

  localparam int TW = FRAC_BITS + 2;
  localparam logic signed [2*TW-1:0] RND = ((2*TW)'(1) << FRAC_BITS) >> 1;

  function automatic logic signed [TW-1:0] mulf(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b;
    p = (p + RND) >>> FRAC_BITS;
    return p[TW-1:0];
  endfunction

  logic signed [TW-1:0] sxsy_r, cxsy_r, cycz_r, cysz_r, cxsz_r, cxcz_r;
  logic signed [TW-1:0] sxcy_r, sxsz_r, sxcz_r, cxcy_r, sy6_r, sz6_r, cz6_r;
  logic signed [TW-1:0] a7_r, b7_r, c7_r, d7_r;
  logic signed [TW-1:0] cycz7_r, cysz7_r, sy7_r, cxsz7_r, cxcz7_r;
  logic signed [TW-1:0] sxcy7_r, sxsz7_r, sxcz7_r, cxcy7_r;
  logic signed [TW:0]   ent_r [9];

  always_ff @(posedge clk) begin
    if (en[STG_PROD1]) begin
      sxsy_r <= mulf(sx, sy);
      cxsy_r <= mulf(cx, sy);
      cycz_r <= mulf(cy, cz);
      cysz_r <= mulf(cy, sz);
      cxsz_r <= mulf(cx, sz);
      cxcz_r <= mulf(cx, cz);
      sxcy_r <= mulf(sx, cy);
      sxsz_r <= mulf(sx, sz);
      sxcz_r <= mulf(sx, cz);
      cxcy_r <= mulf(cx, cy);
      sy6_r  <= sy;
      sz6_r  <= sz;
      cz6_r  <= cz;
    end
    if (en[STG_PROD2]) begin
      a7_r    <= mulf(sxsy_r, cz6_r);
      b7_r    <= mulf(sxsy_r, sz6_r);
      c7_r    <= mulf(cxsy_r, cz6_r);
      d7_r    <= mulf(cxsy_r, sz6_r);
      cycz7_r <= cycz_r;
      cysz7_r <= cysz_r;
      sy7_r   <= sy6_r;
      cxsz7_r <= cxsz_r;
      cxcz7_r <= cxcz_r;
      sxcy7_r <= sxcy_r;
      sxsz7_r <= sxsz_r;
      sxcz7_r <= sxcz_r;
      cxcy7_r <= cxcy_r;
    end
    if (en[STG_SUM]) begin
      ent_r[0] <= (TW+1)'(cycz7_r);
      ent_r[1] <= -(TW+1)'(cysz7_r);
      ent_r[2] <= (TW+1)'(sy7_r);
      ent_r[3] <= (TW+1)'(a7_r) + (TW+1)'(cxsz7_r);
      ent_r[4] <= (TW+1)'(cxcz7_r) - (TW+1)'(b7_r);
      ent_r[5] <= -(TW+1)'(sxcy7_r);
      ent_r[6] <= (TW+1)'(sxsz7_r) - (TW+1)'(c7_r);
      ent_r[7] <= (TW+1)'(d7_r) + (TW+1)'(sxcz7_r);
      ent_r[8] <= (TW+1)'(cxcy7_r);
    end
  end

  assign ent_o = ent_r;

endmodule

`default_nettype wire

@@ hdl/trs_scale.sv @@
// ----------------------------------------------------------------------------
// trs_scale: column scaling and saturation of the rotation entries
// Entry times its Q8.8 column scale, rounded to Q16.16, clamped to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_scale import trs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic [NUM_STAGES-1:0]       en,
  input  wire logic signed [FRAC_BITS+2:0] ent [9],
  input  wire logic signed [15:0]          scale_x,
  input  wire logic signed [15:0]          scale_y,
  input  wire logic signed [15:0]          scale_z,
  output logic signed [31:0]               m_o [9]
);

  localparam int EW = FRAC_BITS + 3;
  localparam int PW = EW + 16;
  localparam int XW = (PW > 33) ? PW : 33;
  localparam int SH = FRAC_BITS - 8;
  localparam logic signed [XW-1:0] RND  = (XW'(1) << SH) >> 1;
  localparam logic signed [XW-1:0] MAXV = XW'(32'h7FFF_FFFF);
  localparam logic signed [XW-1:0] MINV = ~MAXV;

  logic signed [15:0]   col_k [9];
  logic signed [PW-1:0] prod  [9];
  logic signed [XW-1:0] wide  [9];
  logic signed [31:0]   m_nxt [9];
  logic signed [31:0]   m_r   [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      unique case (i % 3)
        0:       col_k[i] = scale_x;
        1:       col_k[i] = scale_y;
        default: col_k[i] = scale_z;
      endcase
      prod[i] = PW'(ent[i]) * PW'(col_k[i]);
      wide[i] = (XW'(prod[i]) + RND) >>> SH;
      if (wide[i] > MAXV)      m_nxt[i] = 32'sh7FFF_FFFF;
      else if (wide[i] < MINV) m_nxt[i] = 32'sh8000_0000;
      else                     m_nxt[i] = wide[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      m_r <= m_nxt;
    end
  end

  assign m_o = m_r;

endmodule

`default_nettype wire

@@ hdl/trs_model_matrix.sv @@
// ----------------------------------------------------------------------------
// trs_model_matrix: streaming builder of the affine model matrix T*Rx*Ry*Rz*S
// Input channel (in_*): position Q16.16, three binary angles, three Q8.8
// scales. Output channel (out_*): the nine upper 3x3 entries, each rotation
// entry times its column scale, saturated Q16.16, plus the translation column,
// a copy of the position.
// Both channels move a transaction when valid is high and stall is low.
// An accepted input passes the nine-stage datapath: five stages of the
// polynomial sine/cosine (a quadrant fold, then one multiply each), two angle
// product stages, one sum stage and one scale and saturate stage. Throughput
// is one transaction per cycle while out_stall is low.
// Each stage holds a valid bit; a stage loads when it is empty or when the
// stage after it moves, so bubbles close up under a stall. in_stall rises
// only when all nine stages hold data and out_stall is high.
// Reset (rst_n low, synchronous) empties the pipeline; no result is pending
// after it. There is no configuration and no state between transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_model_matrix import trs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic [15:0]        in_angle_x,
  input  wire logic [15:0]        in_angle_y,
  input  wire logic [15:0]        in_angle_z,
  input  wire logic signed [15:0] in_scale_x,
  input  wire logic signed [15:0] in_scale_y,
  input  wire logic signed [15:0] in_scale_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_r0c0,
  output logic signed [31:0]      out_r0c1,
  output logic signed [31:0]      out_r0c2,
  output logic signed [31:0]      out_r1c0,
  output logic signed [31:0]      out_r1c1,
  output logic signed [31:0]      out_r1c2,
  output logic signed [31:0]      out_r2c0,
  output logic signed [31:0]      out_r2c1,
  output logic signed [31:0]      out_r2c2,
  output logic signed [31:0]      out_trans_x,
  output logic signed [31:0]      out_trans_y,
  output logic signed [31:0]      out_trans_z
);

  localparam int TW = FRAC_BITS + 2;

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES-1:0] en;
  trs_side_t             side_r [NUM_STAGES];
  trs_side_t             side_in;

  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [TW:0]   ent [9];
  logic signed [31:0]   mat [9];

  // stage k loads when empty or when stage k+1 takes its contents
  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign side_in = '{pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                     scale_x: in_scale_x, scale_y: in_scale_y,
                     scale_z: in_scale_z};

  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= side_in;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
  end

  trs_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_x (
    .clk(clk), .en(en), .angle(in_angle_x), .sin_o(sx), .cos_o(cx)
  );
  trs_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_y (
    .clk(clk), .en(en), .angle(in_angle_y), .sin_o(sy), .cos_o(cy)
  );
  trs_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_z (
    .clk(clk), .en(en), .angle(in_angle_z), .sin_o(sz), .cos_o(cz)
  );

  trs_rotmul #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk(clk), .en(en), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .ent_o(ent)
  );

  trs_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk(clk), .en(en), .ent(ent),
    .scale_x(side_r[STG_SUM].scale_x),
    .scale_y(side_r[STG_SUM].scale_y),
    .scale_z(side_r[STG_SUM].scale_z),
    .m_o(mat)
  );

  assign in_stall    = !en[0];
  assign out_valid   = valid_r[NUM_STAGES-1];
  assign out_r0c0    = mat[0];
  assign out_r0c1    = mat[1];
  assign out_r0c2    = mat[2];
  assign out_r1c0    = mat[3];
  assign out_r1c1    = mat[4];
  assign out_r1c2    = mat[5];
  assign out_r2c0    = mat[6];
  assign out_r2c1    = mat[7];
  assign out_r2c2    = mat[8];
  assign out_trans_x = side_r[STG_OUT].pos_x;
  assign out_trans_y = side_r[STG_OUT].pos_y;
  assign out_trans_z = side_r[STG_OUT].pos_z;

  // input backs up only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (valid_r == '1) && out_stall)
    else $error("in_stall with a free pipeline stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0))
    else $error("pipeline not empty after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_r[0])
    else $error("accepted transaction lost at first stage");

endmodule

`default_nettype wire

@@ bench/tb_trs_model_matrix.sv @@
// ----------------------------------------------------------------------------
// tb_trs_model_matrix: self-checking bench for the TRS model matrix pipeline
// Drives position/angle/scale transactions with random gaps and output
// stalls, predicts each matrix in fixed point and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trs_model_matrix import trs_pkg::*;;

  localparam int AB = ANGLE_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic [15:0]        ax, ay, az;
    logic signed [15:0] kx, ky, kz;
  } xform_t;

  typedef struct {
    logic signed [31:0] m [12];
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [15:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2;
  logic signed [31:0] out_r2c0, out_r2c1, out_r2c2;
  logic signed [31:0] out_trans_x, out_trans_y, out_trans_z;

  matrix_t expected_mats [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  trs_model_matrix dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // -- predictor --------------------------------------------------------------
  function automatic longint rshift(longint v, int n);
    if (n == 0) return v;
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint poly_sine(logic [31:0] t);
    logic [1:0]  q;
    logic [63:0] r, z, z2, inner, t1, s;
    longint      v;
    q = t[31:30];
    r = {34'd0, t[29:0]};
    z = q[0] ? (64'(Q30_ONE) - r) : r;
    z2 = (z * z) >> 30;
    inner = 64'(POLY_B) - ((64'(POLY_C) * z2) >> 30);
    t1 = 64'(POLY_A) - ((z2 * inner) >> 30);
    s = (z * t1) >> 30;
    v = longint'((s + (64'd1 << (29 - FB))) >> (30 - FB));
    return q[1] ? -v : v;
  endfunction

  function automatic logic [31:0] turn_of(logic [15:0] a);
    logic [31:0] t;
    t = 32'(a & ((1 << AB) - 1));
    return t << (32 - AB);
  endfunction

  function automatic longint fmul(longint a, longint b);
    return rshift(a * b, FB);
  endfunction

  function automatic logic signed [31:0] scale_sat(longint e, longint k);
    longint v;
    v = rshift(e * k, FB - 8);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic matrix_t model_matrix(xform_t x);
    matrix_t r;
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint e [9];
    longint k [3];
    sx = poly_sine(turn_of(x.ax)); cx = poly_sine(turn_of(x.ax) + 32'h4000_0000);
    sy = poly_sine(turn_of(x.ay)); cy = poly_sine(turn_of(x.ay) + 32'h4000_0000);
    sz = poly_sine(turn_of(x.az)); cz = poly_sine(turn_of(x.az) + 32'h4000_0000);
    sxsy = fmul(sx, sy);
    cxsy = fmul(cx, sy);
    e[0] = fmul(cy, cz);
    e[1] = -fmul(cy, sz);
    e[2] = sy;
    e[3] = fmul(sxsy, cz) + fmul(cx, sz);
    e[4] = fmul(cx, cz) - fmul(sxsy, sz);
    e[5] = -fmul(sx, cy);
    e[6] = fmul(sx, sz) - fmul(cxsy, cz);
    e[7] = fmul(cxsy, sz) + fmul(sx, cz);
    e[8] = fmul(cx, cy);
    k[0] = x.kx; k[1] = x.ky; k[2] = x.kz;
    for (int i = 0; i < 9; i++) r.m[i] = scale_sat(e[i], k[i % 3]);
    r.m[9] = x.px; r.m[10] = x.py; r.m[11] = x.pz;
    return r;
  endfunction

  // -- driving ----------------------------------------------------------------
  // valid stays up after a transaction; an idle cycle or drain() drops it
  task automatic send_xform(xform_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x.px; in_pos_y <= x.py; in_pos_z <= x.pz;
    in_angle_x <= x.ax; in_angle_y <= x.ay; in_angle_z <= x.az;
    in_scale_x <= x.kx; in_scale_y <= x.ky; in_scale_z <= x.kz;
    do @(posedge clk); while (in_stall);
    expected_mats.push_back(model_matrix(x));
    @(negedge clk);
  endtask

  function automatic xform_t rand_xform();
    xform_t x;
    x.px = $urandom; x.py = $urandom; x.pz = $urandom;
    x.ax = 16'($urandom); x.ay = 16'($urandom); x.az = 16'($urandom);
    case ($urandom_range(3))
      0: begin
        x.kx = 16'($urandom); x.ky = 16'($urandom); x.kz = 16'($urandom);
      end
      1: begin x.kx = 16'sh0100; x.ky = 16'sh0100; x.kz = 16'sh0100; end
      default: begin
        x.kx = 16'($urandom_range(1024) - 512);
        x.ky = 16'($urandom_range(1024) - 512);
        x.kz = 16'($urandom_range(1024) - 512);
      end
    endcase
    // quarter-turn angles hit the exact-axis cases of the sine
    if ($urandom_range(7) == 0) x.ax = 16'($urandom_range(3)) << 14;
    if ($urandom_range(7) == 0) x.ay = 16'($urandom_range(3)) << 14;
    return x;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_mats.size() != 0) @(negedge clk);
  endtask

  // -- checking ---------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    logic signed [31:0] got [12];
    matrix_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
              out_r2c0, out_r2c1, out_r2c2, out_trans_x, out_trans_y, out_trans_z};
      if (expected_mats.size() == 0) begin
        report_mismatch("unexpected transaction", got[0], '0);
      end else begin
        want = expected_mats.pop_front();
        for (int i = 0; i < 12; i++)
          if (got[i] !== want.m[i])
            report_mismatch($sformatf("field %0d", i), got[i], want.m[i]);
      end
    end
  end

  // -- tests ------------------------------------------------------------------
  task automatic test_directed();
    xform_t x;
    logic [15:0] angs [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    logic signed [15:0] scl [5] = '{16'sh7FFF, -16'sh8000, 16'sh0100, 16'sh0000, -16'sh0001};
    logic signed [31:0] pos [3] = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0};
    for (int i = 0; i < 6; i++) begin
      x.px = pos[i % 3]; x.py = pos[(i + 1) % 3]; x.pz = pos[(i + 2) % 3];
      x.ax = angs[i]; x.ay = angs[(i + 2) % 6]; x.az = angs[(i + 4) % 6];
      x.kx = scl[i % 5]; x.ky = scl[(i + 1) % 5]; x.kz = scl[(i + 2) % 5];
      send_xform(x);
    end
    for (int i = 0; i < 10; i++) begin
      x.px = pos[i % 3]; x.py = pos[i % 3]; x.pz = pos[i % 3];
      x.ax = (i < 5) ? 16'hFFFF : 16'h0000; x.ay = angs[i % 6]; x.az = angs[(i + 3) % 6];
      x.kx = scl[i % 5]; x.ky = scl[i % 5]; x.kz = scl[(i + 4) % 5];
      send_xform(x);
    end
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      send_xform(rand_xform());
      // hold off once until the pipe is empty
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 37; recv_idle_pct = 75;
    test_directed();
    drain();
    test_random(250, 37, 75);
    test_random(250, 75, 37);
    test_random(250, 0, 0);
    recv_idle_pct = 0;
    repeat (20) @(negedge clk);
    if (errors == 0) $display("PASS trs_model_matrix");
    else $display("FAIL trs_model_matrix");
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL trs_model_matrix");
    $finish;
  end

endmodule

`default_nettype wire
